// File: src/bmmc_pkg.sv
`timescale 1ns / 1ps

package bmmc_pkg;

	// bus and memory geometry that does not vary
	localparam int ADDR_W    = 24;
	localparam int DATA_W    = 16;
	localparam int CFG_IDX_W = 3;
	localparam int VRAM_BYTES = 65536;
	localparam int VRAM_AW    = 16;
	localparam int CTL_BYTES  = 256;
	localparam int CTL_AW     = 8;

	// access kinds
	localparam logic [1:0] MODE_READ = 2'd0;
	localparam logic [1:0] MODE_WORD = 2'd1;
	localparam logic [1:0] MODE_BYTE = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_VRAM_START = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_VRAM_END   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WRAM_START = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_WRAM_END   = 3'd3;

	// fixed control window addresses
	localparam logic [ADDR_W-1:0] CTL_LOW    = 24'hA13010;
	localparam logic [ADDR_W-1:0] CTL_HIGH   = 24'hA130E0;
	localparam logic [ADDR_W-1:0] CTL_STATUS = 24'hA13011;
	localparam logic [ADDR_W-1:0] MAGIC_LOW  = 24'hA13012;
	localparam logic [ADDR_W-1:0] MAGIC_HIGH = 24'hA13015;
	localparam logic [ADDR_W-1:0] CMD_ADDR   = 24'hA130B0;
	localparam logic [VRAM_AW-1:0] VRAM_MIRROR = 16'h8000;

	// controller to datapath commands
	typedef struct packed {
		logic       clear;
		logic       load;
		logic       red;
		logic       step_en;
		logic [1:0] step;
		logic       cap_hi;
		logic       cap_lo;
		logic       emit;
	} bmmc_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic clr_last;
		logic red_last;
	} bmmc_sts_t;

endpackage

// File: src/bmmc_ram.sv
`timescale 1ns / 1ps

module bmmc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: src/bmmc_datapath.sv
`timescale 1ns / 1ps

module bmmc_datapath #(
	parameter int WRAM_BYTES = 131072
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [bmmc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bmmc_pkg::ADDR_W-1:0]   cfg_data,
	input  logic [1:0]                    mode,
	input  logic [bmmc_pkg::ADDR_W-1:0]   bus_address,
	input  logic [bmmc_pkg::DATA_W-1:0]   write_data,
	input  bmmc_pkg::bmmc_cmd_t           cmd,
	output bmmc_pkg::bmmc_sts_t           sts,
	output logic [bmmc_pkg::DATA_W-1:0]   read_data,
	output logic                          startup_magic_poke,
	output logic                          command_trigger
);

	import bmmc_pkg::*;

	localparam int WA       = $clog2(WRAM_BYTES);
	localparam int CLR_N    = (VRAM_BYTES > WRAM_BYTES) ? VRAM_BYTES : WRAM_BYTES;
	localparam int CW       = $clog2(CLR_N);
	localparam int RED_N    = 2;
	localparam int RCW      = $clog2(RED_N);
	localparam int RSH      = ADDR_W + WA;
	localparam int RECIP_W  = ADDR_W + 2;
	localparam int PROD_W   = ADDR_W + RECIP_W;
	localparam int QW       = ADDR_W - WA + 1;
	localparam longint RECIP = ((longint'(1) << RSH) + longint'(WRAM_BYTES) - 1)
		/ longint'(WRAM_BYTES);
	localparam logic [RECIP_W-1:0] RECIP_K = RECIP_W'(RECIP);
	localparam logic [ADDR_W-1:0]  W_K     = ADDR_W'(WRAM_BYTES);
	localparam logic [WA:0] W_LIM = (WA + 1)'(WRAM_BYTES);

	// configuration
	logic [ADDR_W-1:0] vstart_q, vend_q, wstart_q, wend_q;

	// latched item and decode
	logic [1:0]         mode_q;
	logic [CTL_AW-1:0]  clo_q;
	logic [DATA_W-1:0]  wdata_q;
	logic               hit_v_q, hit_w_q, hit_c_q, ctl_ok_q, magic_q, trig_q;
	logic [VRAM_AW-1:0] vofs_q;
	logic [ADDR_W-1:0]  rem_q;
	logic [QW-1:0]      quo_q;
	logic [RCW-1:0]     rcnt_q;
	logic [CW-1:0]      clr_q;

	// read bytes and result
	logic [7:0]        hi_q, lo_q;
	logic [DATA_W-1:0] rd_out_q;
	logic              magic_out_q, trig_out_q;

	// ram ports
	logic               v_we, w_we, c_we;
	logic [VRAM_AW-1:0] v_addr;
	logic [WA-1:0]      w_addr;
	logic [CTL_AW-1:0]  c_addr;
	logic [7:0]         wbyte;
	logic [7:0]         v_rd, w_rd, c_rd, sel_byte;

	logic              is_wr, is_word, a_hv, a_hw, a_hc, a_wr;
	logic [WA:0]       wofs_inc;
	logic [WA-1:0]     wofs1;
	logic [PROD_W-1:0] quo_prod;
	logic [ADDR_W-1:0] quo_back;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vstart_q <= '0;
			vend_q   <= '0;
			wstart_q <= '0;
			wend_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_VRAM_START: vstart_q <= cfg_data;
				CFG_VRAM_END:   vend_q   <= cfg_data;
				CFG_WRAM_START: wstart_q <= cfg_data;
				CFG_WRAM_END:   wend_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// window decode on the incoming item
	always_comb begin
		a_hv = (bus_address >= vstart_q) && (bus_address <= vend_q);
		a_hw = (bus_address >= wstart_q) && (bus_address <= wend_q);
		a_hc = (bus_address >= CTL_LOW) && (bus_address <= CTL_HIGH);
		a_wr = (mode == MODE_WORD) || (mode == MODE_BYTE);
	end

	// clear pass counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clear) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	// reduction counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rcnt_q <= '0;
		end else if (cmd.load) begin
			rcnt_q <= RCW'(RED_N - 1);
		end else if (cmd.red) begin
			rcnt_q <= rcnt_q - 1'b1;
		end
	end

	// status to the controller
	always_comb begin
		sts.clr_last = (clr_q == CW'(CLR_N - 1));
		sts.red_last = (rcnt_q == '0);
	end

	// quotient by reciprocal multiply, then the product back for the remainder
	always_comb begin
		quo_prod = PROD_W'(rem_q) * PROD_W'(RECIP_K);
		quo_back = ADDR_W'(quo_q) * W_K;
	end

	// item latch and work ram offset reduction: quotient cycle, remainder cycle
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q   <= mode;
			clo_q    <= bus_address[CTL_AW-1:0];
			wdata_q  <= write_data;
			hit_v_q  <= a_hv;
			hit_w_q  <= a_hw;
			hit_c_q  <= a_hc;
			ctl_ok_q <= a_hc && (bus_address != CTL_STATUS);
			magic_q  <= a_wr && a_hc && (bus_address != CTL_STATUS)
				&& (bus_address >= MAGIC_LOW) && (bus_address <= MAGIC_HIGH);
			trig_q   <= a_wr && a_hc && (bus_address == CMD_ADDR);
			vofs_q   <= bus_address[VRAM_AW-1:0] - vstart_q[VRAM_AW-1:0];
			rem_q    <= bus_address - wstart_q;
		end else if (cmd.red) begin
			if (rcnt_q != '0) begin
				quo_q <= quo_prod[RSH +: QW];
			end else begin
				rem_q <= rem_q - quo_back;
			end
		end
	end

	// per-step addresses and enables
	always_comb begin
		is_wr    = (mode_q == MODE_WORD) || (mode_q == MODE_BYTE);
		is_word  = (mode_q == MODE_WORD);
		wofs_inc = {1'b0, rem_q[WA-1:0]} + 1'b1;
		wofs1    = (wofs_inc == W_LIM) ? '0 : wofs_inc[WA-1:0];
		if (cmd.clear) begin
			v_addr = clr_q[VRAM_AW-1:0];
			w_addr = clr_q[WA-1:0];
			c_addr = clr_q[CTL_AW-1:0];
			wbyte  = '0;
			v_we   = 1'b1;
			w_we   = ({1'b0, clr_q} < (CW + 1)'(WRAM_BYTES));
			c_we   = 1'b1;
		end else begin
			v_addr = vofs_q + (cmd.step[1] ? VRAM_MIRROR : '0)
				+ {{(VRAM_AW - 1){1'b0}}, cmd.step[0]};
			w_addr = cmd.step[0] ? wofs1 : rem_q[WA-1:0];
			c_addr = clo_q + {{(CTL_AW - 1){1'b0}}, cmd.step[0]};
			wbyte  = (is_word && !cmd.step[0]) ? wdata_q[15:8] : wdata_q[7:0];
			v_we   = cmd.step_en && is_wr && hit_v_q && (is_word || !cmd.step[0]);
			w_we   = cmd.step_en && is_wr && hit_w_q && !(is_word && hit_v_q)
				&& !cmd.step[1] && (is_word || !cmd.step[0]);
			c_we   = cmd.step_en && is_wr && ctl_ok_q
				&& !cmd.step[1] && (is_word || !cmd.step[0]);
		end
	end

	bmmc_ram #(.WIDTH(8), .DEPTH(VRAM_BYTES)) u_vram (
		.clk   (clk),
		.we    (v_we),
		.waddr (v_addr),
		.wdata (wbyte),
		.raddr (v_addr),
		.rdata (v_rd)
	);

	bmmc_ram #(.WIDTH(8), .DEPTH(WRAM_BYTES)) u_wram (
		.clk   (clk),
		.we    (w_we),
		.waddr (w_addr),
		.wdata (wbyte),
		.raddr (w_addr),
		.rdata (w_rd)
	);

	bmmc_ram #(.WIDTH(8), .DEPTH(CTL_BYTES)) u_ctl (
		.clk   (clk),
		.we    (c_we),
		.waddr (c_addr),
		.wdata (wbyte),
		.raddr (c_addr),
		.rdata (c_rd)
	);

	// video ram wins, then work ram, then control window
	always_comb begin
		if (hit_v_q) begin
			sel_byte = v_rd;
		end else if (hit_w_q) begin
			sel_byte = w_rd;
		end else if (hit_c_q) begin
			sel_byte = c_rd;
		end else begin
			sel_byte = '0;
		end
	end

	// read byte capture, from the ram read of the previous step's address
	always_ff @(posedge clk) begin
		if (cmd.cap_hi) begin
			hi_q <= sel_byte;
		end
		if (cmd.cap_lo) begin
			lo_q <= sel_byte;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			rd_out_q    <= (mode_q == MODE_READ) ? {hi_q, lo_q} : '0;
			magic_out_q <= magic_q;
			trig_out_q  <= trig_q;
		end
	end

	assign read_data          = rd_out_q;
	assign startup_magic_poke = magic_out_q;
	assign command_trigger    = trig_out_q;

endmodule

// File: src/bmmc_ctrl.sv
`timescale 1ns / 1ps

module bmmc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	output bmmc_pkg::bmmc_cmd_t cmd,
	input  bmmc_pkg::bmmc_sts_t sts
);

	import bmmc_pkg::*;

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_RED   = 3'd2;
	localparam logic [2:0] ST_STEP  = 3'd3;
	localparam logic [2:0] ST_DONE  = 3'd4;

	logic [2:0] state_q;
	logic [1:0] step_q;
	logic       out_valid_q;
	logic       accept, emit;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign emit     = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	// command decode
	always_comb begin
		cmd         = '0;
		cmd.clear   = (state_q == ST_CLEAR);
		cmd.load    = accept;
		cmd.red     = (state_q == ST_RED);
		cmd.step_en = (state_q == ST_STEP);
		cmd.step    = step_q;
		cmd.cap_hi  = (state_q == ST_STEP) && (step_q == 2'd1);
		cmd.cap_lo  = (state_q == ST_STEP) && (step_q == 2'd2);
		cmd.emit    = emit;
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			step_q  <= '0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					if (sts.clr_last) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_RED;
					end
				end
				ST_RED: begin
					step_q <= '0;
					if (sts.red_last) begin
						state_q <= ST_STEP;
					end
				end
				ST_STEP: begin
					step_q <= step_q + 1'b1;
					if (step_q == 2'd3) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (emit) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// File: src/bus_mapped_memory_and_control_core.sv
`timescale 1ns / 1ps

// Bus access decoder with video ram, work ram and control byte windows.
// Input channel (in_valid/in_ready) takes one item: mode, bus_address and
// write_data. Output channel (out_valid/out_ready) returns one item per
// input: read_data and the startup_magic_poke / command_trigger flags.
// Window bounds are written through cfg_we/cfg_index/cfg_data; the user must
// write them only while idle, which the block itself does not enforce.
// The work ram offset is reduced modulo WRAM_BYTES (quotient by a
// reciprocal multiply, then the remainder), byte-access steps on the
// rams (word plus mirror) follow, then the result register loads.
// in_ready is high only when the sequencer is idle, so a new item is taken
// only after the last one has reached the result register.
// A finished result sits in the output register; the next item is accepted
// while it waits, and is held in the datapath until out_ready frees it.
// Reset: window registers go to zero, then a clearing pass zeroes all rams,
// one address a cycle over max(65536, WRAM_BYTES) addresses, with in_ready low.
module bus_mapped_memory_and_control_core #(
	parameter int WRAM_BYTES = 131072
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [bmmc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bmmc_pkg::ADDR_W-1:0]   cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    mode,
	input  logic [bmmc_pkg::ADDR_W-1:0]   bus_address,
	input  logic [bmmc_pkg::DATA_W-1:0]   write_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [bmmc_pkg::DATA_W-1:0]   read_data,
	output logic                          startup_magic_poke,
	output logic                          command_trigger
);

	import bmmc_pkg::*;

	bmmc_cmd_t cmd;
	bmmc_sts_t sts;

	// sequencer
	bmmc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	// decode, offsets, memories and result register
	bmmc_datapath #(.WRAM_BYTES(WRAM_BYTES)) u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_we             (cfg_we),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data),
		.mode               (mode),
		.bus_address        (bus_address),
		.write_data         (write_data),
		.cmd                (cmd),
		.sts                (sts),
		.read_data          (read_data),
		.startup_magic_poke (startup_magic_poke),
		.command_trigger    (command_trigger)
	);

endmodule

// File: tb/sv/tb_bus_mapped_memory_and_control_core.sv
`timescale 1ns / 1ps

module tb_bus_mapped_memory_and_control_core;

	import bmmc_pkg::*;

	localparam int WRAM_SIZE = 131072;
	localparam int WRAM_AW = $clog2(WRAM_SIZE);
	localparam int DRAIN_CYCLES = 40;
	localparam int SETTLE_CYCLES = 4;
	// the clearing pass after reset is the longest quiet stretch
	localparam int STALL_LIMIT = 400000;
	localparam int LONG_HOLD = 300;
	localparam int MAX_PRINTED = 50;

	localparam logic [1:0] MODE_NONE = 2'd3;
	localparam logic [ADDR_W-1:0] CTL_BASE = 24'hA13000;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = CFG_WRAM_END + 3'd1;

	typedef struct packed {
		logic [1:0]        mode;
		logic [ADDR_W-1:0] addr;
		logic [DATA_W-1:0] data;
	} bus_access_t;

	typedef struct packed {
		logic [DATA_W-1:0] read_data;
		logic              magic;
		logic              cmd;
	} access_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [ADDR_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] mode = MODE_READ;
	logic [ADDR_W-1:0] bus_address = '0;
	logic [DATA_W-1:0] write_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [DATA_W-1:0] read_data;
	logic startup_magic_poke;
	logic command_trigger;

	bus_mapped_memory_and_control_core #(
		.WRAM_BYTES(WRAM_SIZE)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.mode(mode),
		.bus_address(bus_address),
		.write_data(write_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.read_data(read_data),
		.startup_magic_poke(startup_magic_poke),
		.command_trigger(command_trigger)
	);

	// shadow state of the decoder
	bit [7:0] vram_shadow [VRAM_BYTES];
	bit [7:0] wram_shadow [WRAM_SIZE];
	bit [7:0] ctl_shadow [CTL_BYTES];
	logic [ADDR_W-1:0] vram_lo = '0;
	logic [ADDR_W-1:0] vram_hi = '0;
	logic [ADDR_W-1:0] wram_lo = '0;
	logic [ADDR_W-1:0] wram_hi = '0;

	bus_access_t pending_accesses [$];
	access_result_t predicted_replies [$];
	bus_access_t on_bus;
	int mismatches = 0;
	bit tx_idle_en = 1'b0;
	bit rx_idle_en = 1'b0;
	int hold_requests = 0;
	int hold_served = 0;
	int tx_gap = 0;
	int rx_stall = 0;
	int hold_left = 0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// byte offsets into each store, wrapped to its size
	function automatic logic [15:0] vram_ofs(logic [ADDR_W-1:0] a, logic [31:0] extra);
		logic [31:0] t;
		t = 32'(a) - 32'(vram_lo) + extra;
		return t[15:0];
	endfunction

	function automatic logic [WRAM_AW-1:0] wram_ofs(logic [ADDR_W-1:0] a, logic [31:0] extra);
		logic [31:0] t;
		t = 32'(a) - 32'(wram_lo) + extra;
		return t[WRAM_AW-1:0];
	endfunction

	function automatic logic [CTL_AW-1:0] ctl_ofs(logic [ADDR_W-1:0] a, logic [31:0] extra);
		logic [31:0] t;
		t = 32'(a) - 32'(CTL_BASE) + extra;
		return t[CTL_AW-1:0];
	endfunction

	// decode one access against the shadow stores and return its result
	function automatic access_result_t decode_access(bus_access_t acc);
		access_result_t res;
		logic hit_v, hit_w, hit_c, is_word;
		logic [7:0] hi_b, lo_b;
		logic [31:0] mirror;
		res = '0;
		mirror = 32'(VRAM_MIRROR);
		hit_v = acc.addr >= vram_lo && acc.addr <= vram_hi;
		hit_w = acc.addr >= wram_lo && acc.addr <= wram_hi;
		hit_c = acc.addr >= CTL_LOW && acc.addr <= CTL_HIGH;
		hi_b = acc.data[15:8];
		lo_b = acc.data[7:0];
		is_word = acc.mode == MODE_WORD;
		case (acc.mode)
		MODE_READ: begin
			// video ram first, then work ram, control only when no ram matched
			if (hit_v)
				res.read_data = {vram_shadow[vram_ofs(acc.addr, 0)],
					vram_shadow[vram_ofs(acc.addr, 1)]};
			else if (hit_w)
				res.read_data = {wram_shadow[wram_ofs(acc.addr, 0)],
					wram_shadow[wram_ofs(acc.addr, 1)]};
			else if (hit_c)
				res.read_data = {ctl_shadow[ctl_ofs(acc.addr, 0)],
					ctl_shadow[ctl_ofs(acc.addr, 1)]};
		end
		MODE_WORD, MODE_BYTE: begin
			// video ram with its mirror copy
			if (hit_v) begin
				if (is_word) begin
					vram_shadow[vram_ofs(acc.addr, 0)] = hi_b;
					vram_shadow[vram_ofs(acc.addr, 1)] = lo_b;
					vram_shadow[vram_ofs(acc.addr, mirror)] = hi_b;
					vram_shadow[vram_ofs(acc.addr, mirror + 1)] = lo_b;
				end else begin
					vram_shadow[vram_ofs(acc.addr, 0)] = lo_b;
					vram_shadow[vram_ofs(acc.addr, mirror)] = lo_b;
				end
			end
			// byte writes reach work ram even when video ram matched
			if (hit_w && (!is_word || !hit_v)) begin
				if (is_word) begin
					wram_shadow[wram_ofs(acc.addr, 0)] = hi_b;
					wram_shadow[wram_ofs(acc.addr, 1)] = lo_b;
				end else begin
					wram_shadow[wram_ofs(acc.addr, 0)] = lo_b;
				end
			end
			// control window, status byte is read only
			if (hit_c && acc.addr != CTL_STATUS) begin
				if (is_word) begin
					ctl_shadow[ctl_ofs(acc.addr, 0)] = hi_b;
					ctl_shadow[ctl_ofs(acc.addr, 1)] = lo_b;
				end else begin
					ctl_shadow[ctl_ofs(acc.addr, 0)] = lo_b;
				end
				res.magic = acc.addr >= MAGIC_LOW && acc.addr <= MAGIC_HIGH;
				res.cmd = acc.addr == CMD_ADDR;
			end
		end
		default: ;
		endcase
		return res;
	endfunction

	// addresses clustered on window edges, the mirror and control hot spots
	function automatic logic [ADDR_W-1:0] hot_address();
		logic [ADDR_W-1:0] a;
		case ($urandom_range(0, 10))
		0, 1: a = ADDR_W'(vram_lo + $urandom_range(0, 47));
		2: a = ADDR_W'(vram_hi - $urandom_range(0, 47));
		3: a = ADDR_W'(vram_lo + VRAM_MIRROR + $urandom_range(0, 47));
		4, 5: a = ADDR_W'(wram_lo + $urandom_range(0, 47));
		6: a = ADDR_W'(wram_hi - $urandom_range(0, 47));
		7: a = $urandom_range(0, 1) ? CMD_ADDR : ADDR_W'(CTL_STATUS + $urandom_range(0, 5));
		8: a = ADDR_W'(CTL_LOW - 4 + $urandom_range(0, 'hD8));
		default: a = ADDR_W'($urandom());
		endcase
		return a;
	endfunction

	function automatic bus_access_t random_access();
		bus_access_t acc;
		int pick;
		pick = $urandom_range(0, 18);
		if (pick < 8)
			acc.mode = MODE_READ;
		else if (pick < 13)
			acc.mode = MODE_WORD;
		else if (pick < 18)
			acc.mode = MODE_BYTE;
		else
			acc.mode = MODE_NONE;
		acc.addr = hot_address();
		case ($urandom_range(0, 7))
		0: acc.data = '0;
		1: acc.data = '1;
		default: acc.data = DATA_W'($urandom());
		endcase
		return acc;
	endfunction

	task automatic report_mismatch(string msg);
		if (mismatches < MAX_PRINTED)
			$display("%0t mismatch: %s", $realtime, msg);
		mismatches++;
	endtask

	task automatic push_access(logic [1:0] m, logic [ADDR_W-1:0] a, logic [DATA_W-1:0] d);
		bus_access_t acc;
		acc.mode = m;
		acc.addr = a;
		acc.data = d;
		pending_accesses.push_back(acc);
	endtask

	// register write while idle, shadow copy follows
	task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [ADDR_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
		case (idx)
		CFG_VRAM_START: vram_lo = val;
		CFG_VRAM_END: vram_hi = val;
		CFG_WRAM_START: wram_lo = val;
		CFG_WRAM_END: wram_hi = val;
		default: ;
		endcase
	endtask

	task automatic set_windows(logic [ADDR_W-1:0] v_lo, v_hi, w_lo, w_hi);
		cfg_write(CFG_VRAM_START, v_lo);
		cfg_write(CFG_VRAM_END, v_hi);
		cfg_write(CFG_WRAM_START, w_lo);
		cfg_write(CFG_WRAM_END, w_hi);
	endtask

	task automatic wait_drained();
		while (pending_accesses.size() != 0 || in_valid || predicted_replies.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic run_phase(input logic [ADDR_W-1:0] v_lo, v_hi, w_lo, w_hi,
		input int count, input bit idle, input bit long_hold);
		set_windows(v_lo, v_hi, w_lo, w_hi);
		tx_idle_en = idle;
		rx_idle_en = idle;
		for (int i = 0; i < count; i++)
			pending_accesses.push_back(random_access());
		if (long_hold)
			hold_requests++;
		wait_drained();
	endtask

	// driver: present queued items, predict each on acceptance
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			mode <= MODE_READ;
			bus_address <= '0;
			write_data <= '0;
			tx_gap = 0;
		end else begin
			if (in_valid && in_ready)
				predicted_replies.push_back(decode_access(on_bus));
			if (!in_valid || in_ready) begin
				if (tx_gap > 0) begin
					tx_gap--;
					in_valid <= 1'b0;
				end else if (pending_accesses.size() != 0) begin
					on_bus = pending_accesses.pop_front();
					in_valid <= 1'b1;
					mode <= on_bus.mode;
					bus_address <= on_bus.addr;
					write_data <= on_bus.data;
					if (tx_idle_en && $urandom_range(0, 5) == 0)
						tx_gap = $urandom_range(1, 3);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver: short random stalls plus a long hold on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			rx_stall = 0;
			hold_left = 0;
		end else begin
			if (hold_left == 0 && hold_served != hold_requests) begin
				hold_served++;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (rx_stall > 0) begin
				rx_stall--;
				out_ready <= 1'b0;
			end else if (rx_idle_en && $urandom_range(0, 4) == 0) begin
				rx_stall = $urandom_range(0, 2);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// monitor: compare each result item with the oldest prediction
	always @(posedge clk) begin : result_check
		access_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (predicted_replies.size() == 0) begin
				report_mismatch($sformatf("unexpected item read_data=%h", read_data));
			end else begin
				want = predicted_replies.pop_front();
				if (read_data !== want.read_data)
					report_mismatch($sformatf("read_data %h, want %h",
						read_data, want.read_data));
				if (startup_magic_poke !== want.magic)
					report_mismatch($sformatf("startup_magic_poke %b, want %b",
						startup_magic_poke, want.magic));
				if (command_trigger !== want.cmd)
					report_mismatch($sformatf("command_trigger %b, want %b",
						command_trigger, want.cmd));
			end
		end
	end

	// watchdog on cycles with no item moving on either side
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin : stimulus
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		// rams are cleared after reset before the first item
		while (!in_ready)
			@(negedge clk);

		// directed accesses
		set_windows(24'h200000, 24'h20FFFF, 24'hFE0000, 24'hFFFFFF);
		cfg_write(CFG_SPARE + 3'($urandom_range(0, 3)), '1);
		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
		push_access(MODE_WORD, 24'h200000, 16'hA55A);
		push_access(MODE_READ, 24'h200000, 16'h0000);
		push_access(MODE_READ, 24'h208000, 16'h0000);
		// word at the last video ram byte wraps to offset zero
		push_access(MODE_WORD, 24'h20FFFF, 16'h1234);
		push_access(MODE_READ, 24'h20FFFF, 16'h0000);
		push_access(MODE_READ, 24'h207FFF, 16'h0000);
		push_access(MODE_BYTE, 24'h200001, 16'hFFEE);
		push_access(MODE_READ, 24'h200000, 16'h0000);
		// work ram wrap at the top of the bus
		push_access(MODE_WORD, 24'hFFFFFF, 16'hFFFF);
		push_access(MODE_READ, 24'hFE0000, 16'h0000);
		push_access(MODE_READ, 24'hFFFFFF, 16'h0000);
		// control window, status byte and flags
		push_access(MODE_WORD, CTL_LOW, 16'hBEEF);
		push_access(MODE_BYTE, CTL_STATUS, 16'h0077);
		push_access(MODE_WORD, CTL_STATUS, 16'h0102);
		push_access(MODE_READ, CTL_LOW, 16'h0000);
		push_access(MODE_WORD, MAGIC_LOW, 16'h0000);
		push_access(MODE_BYTE, MAGIC_HIGH, 16'h00C3);
		push_access(MODE_WORD, CMD_ADDR, 16'h0001);
		push_access(MODE_WORD, CTL_HIGH, 16'h5AA5);
		push_access(MODE_READ, CTL_HIGH, 16'h0000);
		push_access(MODE_READ, ADDR_W'(CTL_HIGH + 1), 16'h0000);
		push_access(MODE_BYTE, ADDR_W'(CTL_LOW - 1), 16'hFFFF);
		push_access(MODE_NONE, CMD_ADDR, 16'hFFFF);
		push_access(MODE_READ, 24'h000000, 16'h0000);
		wait_drained();

		// overlapping windows across the control window, with a long hold
		run_phase(24'hA13080, 24'hA1FFFF, 24'hA13000, 24'hA3FFFF, 225, 1'b1, 1'b1);
		// empty video ram window, work ram over the whole bus
		run_phase(24'h400000, 24'h3FFFFF, 24'h000000, 24'hFFFFFF, 225, 1'b1, 1'b0);
		// video ram over the whole bus, one byte of work ram at the top
		run_phase(24'h000000, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 225, 1'b1, 1'b0);
		// all bounds zero
		run_phase(24'h000000, 24'h000000, 24'h000000, 24'h000000, 225, 1'b1, 1'b0);
		// last part runs without idling
		run_phase(24'hA12FF0, 24'hA1300F, 24'h123456, 24'h13FFFF, 225, 1'b0, 1'b0);

		repeat (DRAIN_CYCLES) @(negedge clk);
		if (predicted_replies.size() != 0)
			report_mismatch($sformatf("%0d items never returned", predicted_replies.size()));
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
